### rtl/box_mean_filter_7x7_macros.svh
// Assertion macros shared by the box mean filter modules.
`ifndef BOX_MEAN_FILTER_7X7_MACROS_SVH
`define BOX_MEAN_FILTER_7X7_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BMF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bmf_pkg.sv
// Types and constants shared by the box mean filter modules.
`timescale 1ns / 1ps
package bmf_pkg;

	localparam int PIX_W       = 8;
	localparam int ROW_W       = 9;
	localparam int COORD_W     = 9;
	localparam int CFG_W       = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int MAX_HEIGHT  = 512;
	localparam int FIFO_DEPTH  = 8;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * COORD_W + PIX_W);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Per-pixel side information that rides along with the data path.
	typedef struct packed {
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
		logic               emit;
		logic               mean_ok;
		logic               rows_ok;
		logic               last;
	} bmf_tag_t;

	// One output pixel as held in the output queue.
	typedef struct packed {
		logic               last;
		logic [PIX_W-1:0]   value;
		logic [COORD_W-1:0] out_col;
		logic [COORD_W-1:0] out_row;
	} bmf_result_t;

endpackage

### rtl/box_mean_filter_7x7.sv
// Top level of the box mean filter over a raster-order greyscale pixel stream.
`timescale 1ns / 1ps
`include "box_mean_filter_7x7_macros.svh"
// Usage:
// Pixels enter on the s_axis channel in raster order, one 8-bit pixel per beat.
// When pixel (r,c) with r and c both at least RADIUS arrives, the filter emits
// output pixel (r-RADIUS, c-RADIUS) on m_axis: the truncated mean of the square
// window centred there, or zero when that centre is closer than RADIUS to an edge.
// tlast marks the pixel emitted by the frame's final input beat.
// The cfg channel writes image_width (index 0) or image_height (index 1); a write
// restarts the frame. Write it only while no pixel is in flight. cfg_ready is
// always high.
// Throughput is one pixel per cycle while s_axis_tready is high. The line store
// is a single memory word per column holding all 2*RADIUS stored lines, read and
// written once per pixel; the column sum, window sum and product are registered.
// The receiver may stall: results collect in an 8-entry queue and s_axis_tready
// drops once the queue plus the pixels in flight would fill it.
// Reset clears the counters, the window and the queue and sets both dimensions to
// 512. The line store needs no clearing: rows are always rewritten before use.
module box_mean_filter_7x7 import bmf_pkg::*; #(
	parameter int MAX_WIDTH = 512,
	parameter int RADIUS    = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [8:0] out_row, [17:9] out_col,
	                                               // [25:18] value, [31:26] zero
	output logic                   m_axis_tlast,   // frame_last
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int KSIZE  = 2 * RADIUS + 1;
	localparam int LINES  = 2 * RADIUS;
	localparam int COL_W  = $clog2(KSIZE * 255 + 1);
	localparam int COL_CW = $clog2(MAX_WIDTH);
	localparam int W_W    = COL_CW + 1;
	localparam int CMP_W  = (W_W > CFG_W) ? W_W : CFG_W;
	localparam int OCC_W  = $clog2(FIFO_DEPTH + 1);

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_CW-1:0] col_q;
	logic [OCC_W-1:0]  inflight_q;

	logic [CMP_W-1:0]  w_raw;
	logic [W_W-1:0]    w_eff;
	logic [CFG_W-1:0]  h_eff;
	logic [ROW_W-1:0]  r_cur;
	logic [COL_CW-1:0] c_cur;
	logic [ROW_W-1:0]  row_next;
	logic [COL_CW-1:0] col_next;
	logic              accept;
	logic              cfg_beat;
	logic              cfg_hit;
	logic              pos_ok;
	bmf_tag_t          in_tag;

	logic              ls_valid;
	logic [COL_W-1:0]  ls_colsum;
	bmf_tag_t          ls_tag;
	logic              win_valid;
	logic [PIX_W-1:0]  win_value;
	bmf_tag_t          win_tag;

	bmf_result_t       push_data;
	bmf_result_t       fifo_data;
	logic [OCC_W-1:0]  fifo_count;
	logic [OCC_W-1:0]  occ;

	// Out-of-range dimensions are clamped: zero means one, and anything above
	// the maximum means the maximum.
	always_comb begin
		w_raw = CMP_W'(width_q);
		if (width_q == '0) begin
			w_eff = W_W'(1);
		end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
			w_eff = W_W'(MAX_WIDTH);
		end else begin
			w_eff = W_W'(w_raw);
		end
		if (height_q == '0) begin
			h_eff = CFG_W'(1);
		end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// Position of the pixel now on the input and where the next one lands.
	always_comb begin
		c_cur = (W_W'(col_q) >= w_eff) ? '0 : col_q;
		r_cur = (CFG_W'(row_q) >= h_eff) ? '0 : row_q;
		if (W_W'(c_cur) == w_eff - W_W'(1)) begin
			col_next = '0;
			row_next = (CFG_W'(r_cur) == h_eff - CFG_W'(1)) ? '0 : r_cur + 1'b1;
		end else begin
			col_next = c_cur + 1'b1;
			row_next = r_cur;
		end
	end

	// The output pixel trails the input by RADIUS rows and columns. Only a
	// centre at least RADIUS from the top and left edges gets a real mean;
	// bottom and right border outputs are never produced at all. Column sums
	// from the first 2*RADIUS rows never reach a real mean.
	always_comb begin
		in_tag.out_row = COORD_W'(r_cur - ROW_W'(RADIUS));
		in_tag.out_col = COORD_W'(c_cur - COL_CW'(RADIUS));
		in_tag.emit    = (r_cur >= ROW_W'(RADIUS)) && (c_cur >= COL_CW'(RADIUS));
		in_tag.mean_ok = (r_cur >= ROW_W'(LINES)) && (c_cur >= COL_CW'(LINES));
		in_tag.rows_ok = (r_cur >= ROW_W'(LINES));
		in_tag.last    = (CFG_W'(r_cur) == h_eff - CFG_W'(1))
		              && (W_W'(c_cur) == w_eff - W_W'(1));
	end

	// Input is taken only while every pixel already in flight is sure of a
	// queue slot, so the pipeline itself never has to stall.
	assign occ           = inflight_q + fifo_count;
	assign s_axis_tready = (occ < OCC_W'(FIFO_DEPTH));
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign cfg_beat      = cfg_valid && cfg_ready;
	assign cfg_hit       = cfg_beat
	                    && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
	assign pos_ok        = (W_W'(col_q) < w_eff) && (CFG_W'(row_q) < h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= CFG_W'(512);
			height_q   <= CFG_W'(512);
			row_q      <= '0;
			col_q      <= '0;
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + OCC_W'(accept) - OCC_W'(win_valid);
			if (cfg_beat) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						width_q <= cfg_data;
						row_q   <= '0;
						col_q   <= '0;
					end
					REG_IMAGE_HEIGHT: begin
						height_q <= cfg_data;
						row_q    <= '0;
						col_q    <= '0;
					end
					default: begin
					end
				endcase
			end else if (accept) begin
				row_q <= row_next;
				col_q <= col_next;
			end
		end
	end

	bmf_line_store #(
		.DEPTH (MAX_WIDTH),
		.LINES (LINES),
		.COL_W (COL_W)
	) u_line_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.in_addr    (c_cur),
		.in_pixel   (s_axis_tdata),
		.in_tag     (in_tag),
		.out_valid  (ls_valid),
		.out_colsum (ls_colsum),
		.out_tag    (ls_tag)
	);

	bmf_window_sum #(
		.KSIZE (KSIZE),
		.COL_W (COL_W)
	) u_window_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ls_valid),
		.in_colsum (ls_colsum),
		.in_tag    (ls_tag),
		.out_valid (win_valid),
		.out_value (win_value),
		.out_tag   (win_tag)
	);

	always_comb begin
		push_data.last    = win_tag.last;
		push_data.value   = win_value;
		push_data.out_col = win_tag.out_col;
		push_data.out_row = win_tag.out_row;
	end

	bmf_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (win_valid && win_tag.emit),
		.push_data (push_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (fifo_data),
		.count     (fifo_count)
	);

	assign m_axis_tdata = {OUT_PAD_W'(0), fifo_data.value, fifo_data.out_col, fifo_data.out_row};
	assign m_axis_tlast = fifo_data.last;

	`BMF_ASSERT_SAME(a_occ_bound, 1'b1, occ <= OCC_W'(FIFO_DEPTH), "too many pixels in flight")
	`BMF_ASSERT_NEXT(a_cfg_restart, cfg_hit, (row_q == '0) && (col_q == '0), "frame not restarted")
	`BMF_ASSERT_SAME(a_pos_in_frame, 1'b1, pos_ok, "position counters left the frame")

endmodule

### rtl/bmf_line_store.sv
// Line store memory: reads one column, shifts in the new pixel, writes it back.
`timescale 1ns / 1ps
module bmf_line_store import bmf_pkg::*; #(
	parameter int DEPTH = 512,
	parameter int LINES = 6,
	parameter int COL_W = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [$clog2(DEPTH)-1:0] in_addr,
	input  logic [PIX_W-1:0]         in_pixel,
	input  bmf_tag_t                 in_tag,
	output logic                     out_valid,
	output logic [COL_W-1:0]         out_colsum,
	output bmf_tag_t                 out_tag
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WORD_W = LINES * PIX_W;

	logic [WORD_W-1:0] mem [DEPTH];

	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [PIX_W-1:0]  pixel_s1;
	bmf_tag_t          tag_s1;
	logic [WORD_W-1:0] rd_word_s1;
	logic              fwd_s1;
	logic [WORD_W-1:0] fwd_word_s1;

	logic [WORD_W-1:0] old_word;
	logic [WORD_W-1:0] new_word;
	logic [COL_W-1:0]  colsum;

	logic              valid_s2;
	logic [COL_W-1:0]  colsum_s2;
	bmf_tag_t          tag_s2;

	// Line k sits at bits [k*8 +: 8], oldest row in line 0.
	always_comb begin
		old_word = fwd_s1 ? fwd_word_s1 : rd_word_s1;
		new_word = {pixel_s1, old_word[WORD_W-1:PIX_W]};
		colsum   = COL_W'(pixel_s1);
		for (int k = 0; k < LINES; k++) begin
			colsum = colsum + COL_W'(old_word[k*PIX_W +: PIX_W]);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			rd_word_s1 <= mem[in_addr];
		end
		if (valid_s1) begin
			mem[addr_s1] <= new_word;
		end
	end

	// A read issued in the same cycle as the write to that column sees stale
	// data, so the written word is carried forward instead.
	// A column from the first rows of a frame never enters a full window, so
	// its sum is forced to zero; this keeps never-written memory words out of
	// the running window sum.
	always_ff @(posedge clk) begin
		addr_s1     <= in_addr;
		pixel_s1    <= in_pixel;
		tag_s1      <= in_tag;
		fwd_s1      <= valid_s1 && (addr_s1 == in_addr);
		fwd_word_s1 <= new_word;
		colsum_s2   <= tag_s1.rows_ok ? colsum : '0;
		tag_s2      <= tag_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign out_colsum = colsum_s2;
	assign out_tag    = tag_s2;

endmodule

### rtl/bmf_window_sum.sv
// Window sum from running column sums, then division by the window area.
`timescale 1ns / 1ps
module bmf_window_sum import bmf_pkg::*; #(
	parameter int KSIZE = 7,
	parameter int COL_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [COL_W-1:0] in_colsum,
	input  bmf_tag_t         in_tag,
	output logic             out_valid,
	output logic [PIX_W-1:0] out_value,
	output bmf_tag_t         out_tag
);

	localparam int AREA      = KSIZE * KSIZE;
	localparam int SUM_W     = $clog2(AREA * 255 + 1);
	// Reciprocal error stays below one part in AREA for every reachable sum.
	localparam int DIV_SHIFT = SUM_W + 6;
	localparam int MUL_W     = DIV_SHIFT - $clog2(AREA) + 2;
	localparam int PROD_W    = SUM_W + MUL_W;
	localparam logic [MUL_W-1:0] RECIP = MUL_W'(((2 ** DIV_SHIFT) + AREA - 1) / AREA);

	logic [COL_W-1:0]  col_q [KSIZE];
	logic [SUM_W-1:0]  sum_q;

	logic              valid_s3;
	bmf_tag_t          tag_s3;
	logic              valid_s4;
	bmf_tag_t          tag_s4;
	logic [PROD_W-1:0] prod_s4;

	// The window sum follows the column sums exactly: add the newest, drop the oldest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KSIZE; i++) begin
				col_q[i] <= '0;
			end
			sum_q    <= '0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (in_valid) begin
				for (int i = 0; i < KSIZE - 1; i++) begin
					col_q[i] <= col_q[i+1];
				end
				col_q[KSIZE-1] <= in_colsum;
				sum_q <= sum_q + SUM_W'(in_colsum) - SUM_W'(col_q[0]);
			end
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s3  <= in_tag;
		tag_s4  <= tag_s3;
		prod_s4 <= PROD_W'(sum_q) * PROD_W'(RECIP);
	end

	assign out_valid = valid_s4;
	assign out_tag   = tag_s4;
	assign out_value = tag_s4.mean_ok ? prod_s4[DIV_SHIFT +: PIX_W] : '0;

endmodule

### rtl/bmf_out_fifo.sv
// Output queue that decouples the filter pipeline from the downstream receiver.
`timescale 1ns / 1ps
`include "box_mean_filter_7x7_macros.svh"
module bmf_out_fifo import bmf_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  bmf_result_t                push_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output bmf_result_t                out_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	bmf_result_t      slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign count     = cnt_q;

	`BMF_ASSERT_SAME(a_no_overflow, push && !pop, cnt_q < CNT_W'(DEPTH), "output queue overflow")
	`BMF_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not rise")
	`BMF_ASSERT_NEXT(a_cnt_down, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "queue count did not fall")

endmodule

### bench/tb_top.sv
// Self-checking bench for the 7x7 box mean filter: random pixel streams, frame sizes, stalls.
`timescale 1ns / 1ps
module tb_top;
	import bmf_pkg::*;

	// Geometry of the filter as instantiated (default parameters of the block).
	localparam int LINE_LEN     = 512;             // longest row the line store holds
	localparam int WIN_RADIUS   = 3;
	localparam int WIN_SPAN     = 2 * WIN_RADIUS + 1;
	localparam int STORED_LINES = 2 * WIN_RADIUS;
	localparam int WIN_AREA     = WIN_SPAN * WIN_SPAN;

	// Stimulus and timing knobs.
	localparam int RANDOM_PIXELS  = 300;
	localparam int MAX_IDLE       = 17;    // longest gap or stall drawn per beat
	localparam int SETTLE_CYCLES  = 10;    // lets the pipeline empty after the last owed output
	localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before the run is abandoned
	localparam int PRINT_LIMIT    = 100;

	// An index outside the register map; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd2;

	typedef enum {PAT_RANDOM, PAT_WHITE, PAT_BLACK, PAT_CHECKER} pixel_pattern_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [PIX_W-1:0]       s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_W-1:0]       cfg_data      = '0;

	box_mean_filter_7x7 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the filter. It is advanced on every accepted input
	// beat and on every register write, exactly at the clock edge where
	// the block itself sees the beat.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] line_px   [0:STORED_LINES-1][0:LINE_LEN-1];
	logic [PIX_W-1:0] window_px [0:WIN_SPAN-1][0:WIN_SPAN-1];
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	int unsigned      row_pos;
	int unsigned      col_pos;

	// Output pixels the block still owes, oldest first.
	bmf_result_t expected_pixels[$];

	// Pixels waiting to be driven, and the counts used to tell when the
	// input side has gone quiet.
	logic [PIX_W-1:0] pixel_stream[$];
	int               pixels_queued = 0;
	int               pixels_sent   = 0;
	int               mismatches    = 0;

	// Beats seen at the last rising edge, used by the drivers at the
	// following falling edge.
	logic pixel_taken  = 1'b0;
	logic result_taken = 1'b0;

	// When set, the matching side runs with no idle cycles at all.
	logic send_burst = 1'b0;
	logic recv_burst = 1'b0;
	int   send_wait  = 0;
	int   recv_wait  = 0;

	task clear_model();
		for (int i = 0; i < STORED_LINES; i++)
			for (int j = 0; j < LINE_LEN; j++)
				line_px[i][j] = '0;
		for (int i = 0; i < WIN_SPAN; i++)
			for (int j = 0; j < WIN_SPAN; j++)
				window_px[i][j] = '0;
		width_reg  = CFG_W'(LINE_LEN);
		height_reg = CFG_W'(MAX_HEIGHT);
		row_pos    = 0;
		col_pos    = 0;
	endtask

	// A write to either dimension restarts the frame; other indexes are ignored.
	task load_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		case (idx)
			REG_IMAGE_WIDTH: begin
				width_reg = val;
				row_pos   = 0;
				col_pos   = 0;
			end
			REG_IMAGE_HEIGHT: begin
				height_reg = val;
				row_pos    = 0;
				col_pos    = 0;
			end
			default: ;
		endcase
	endtask

	// Push one pixel through line store and window and queue the output
	// pixel it releases, if any.
	task filter_pixel(input logic [PIX_W-1:0] px);
		int unsigned      w;
		int unsigned      h;
		int unsigned      r;
		int unsigned      c;
		int unsigned      sum;
		logic [PIX_W-1:0] column [0:WIN_SPAN-1];
		bmf_result_t      res;

		// Zero counts as one; anything past the maximum counts as the maximum.
		w = (width_reg == 0) ? 1 : ((width_reg > LINE_LEN) ? LINE_LEN : width_reg);
		h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
		r = (row_pos >= h) ? 0 : row_pos;
		c = (col_pos >= w) ? 0 : col_pos;

		for (int k = 0; k < STORED_LINES; k++)
			column[k] = line_px[k][c];
		column[STORED_LINES] = px;
		for (int k = 0; k < STORED_LINES; k++)
			line_px[k][c] = column[k + 1];

		for (int i = 0; i < WIN_SPAN; i++) begin
			for (int j = 0; j < WIN_SPAN - 1; j++)
				window_px[i][j] = window_px[i][j + 1];
			window_px[i][WIN_SPAN - 1] = column[i];
		end

		if (r >= WIN_RADIUS && c >= WIN_RADIUS) begin
			sum = 0;
			// Only a window lying wholly inside the frame gives a mean;
			// the top and left border come out as zero.
			if (r >= STORED_LINES && c >= STORED_LINES)
				for (int i = 0; i < WIN_SPAN; i++)
					for (int j = 0; j < WIN_SPAN; j++)
						sum += window_px[i][j];
			res.out_row = COORD_W'(r - WIN_RADIUS);
			res.out_col = COORD_W'(c - WIN_RADIUS);
			res.value   = PIX_W'(sum / WIN_AREA);
			res.last    = (r == h - 1) && (c == w - 1);
			expected_pixels.push_back(res);
		end

		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		row_pos = r;
		col_pos = c;
	endtask

	task report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Pixel driver: presents the next queued pixel after the gap drawn
	// for it. Inputs move on the falling edge only.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_pixels
		logic             next_valid;
		logic [PIX_W-1:0] next_data;

		next_valid = s_axis_tvalid;
		next_data  = s_axis_tdata;
		if (arst_n) begin
			if (pixel_taken) begin
				next_valid = 1'b0;
				send_wait  = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (!next_valid) begin
				if (send_wait > 0) begin
					send_wait = send_wait - 1;
				end else if (pixel_stream.size() > 0) begin
					next_data  = pixel_stream.pop_front();
					next_valid = 1'b1;
				end
			end
		end
		s_axis_tvalid <= next_valid;
		s_axis_tdata  <= next_data;
	end

	// Result sink: after each output beat it holds ready low for a drawn
	// number of cycles, so back-pressure lands on every pipeline phase.
	always @(negedge clk) begin : drive_ready
		if (arst_n) begin
			if (result_taken)
				recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
			if (recv_wait > 0) begin
				recv_wait = recv_wait - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge. Output beats are
	// checked against the oldest expectation before this edge's input
	// beat is folded into the shadow model.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		bmf_result_t want;

		pixel_taken  = arst_n && s_axis_tvalid && s_axis_tready;
		result_taken = arst_n && m_axis_tvalid && m_axis_tready;

		if (result_taken) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("output beat with nothing expected, tdata 0x%08h",
					m_axis_tdata));
			end else begin
				want = expected_pixels.pop_front();
				if (m_axis_tdata[COORD_W-1:0] !== want.out_row)
					report_mismatch($sformatf("out_row got %0d want %0d",
						m_axis_tdata[COORD_W-1:0], want.out_row));
				if (m_axis_tdata[2*COORD_W-1:COORD_W] !== want.out_col)
					report_mismatch($sformatf("out_col got %0d want %0d (row %0d)",
						m_axis_tdata[2*COORD_W-1:COORD_W], want.out_col, want.out_row));
				if (m_axis_tdata[2*COORD_W+PIX_W-1:2*COORD_W] !== want.value)
					report_mismatch($sformatf("value got %0d want %0d at (%0d,%0d)",
						m_axis_tdata[2*COORD_W+PIX_W-1:2*COORD_W], want.value,
						want.out_row, want.out_col));
				if (m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0)
					report_mismatch($sformatf("padding bits not zero, tdata 0x%08h",
						m_axis_tdata));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("tlast got %0b want %0b at (%0d,%0d)",
						m_axis_tlast, want.last, want.out_row, want.out_col));
			end
		end

		if (arst_n && cfg_valid && cfg_ready)
			load_register(cfg_index, cfg_data);

		if (pixel_taken) begin
			filter_pixel(s_axis_tdata);
			pixels_sent++;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers, used only by the sequence below.
	// ------------------------------------------------------------------
	task queue_pixels(input int count, input pixel_pattern_t pat);
		logic [PIX_W-1:0] px;

		for (int i = 0; i < count; i++) begin
			case (pat)
				PAT_WHITE:   px = '1;
				PAT_BLACK:   px = '0;
				PAT_CHECKER: px = (i % 2) ? 8'hAA : 8'h55;
				default:     px = $urandom_range(0, 255);
			endcase
			pixel_stream.push_back(px);
			pixels_queued++;
		end
	endtask

	// Hold until every queued pixel has gone in and every owed output has
	// come out, then let the pipeline empty of pixels that owe nothing.
	task wait_drained();
		while (pixels_sent != pixels_queued || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task set_frame(input int w, input int h);
		write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin : stimulus
		int             w;
		int             h;
		int             npix;
		int             half;
		int             first_random;
		pixel_pattern_t pat;

		clear_model();
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero dimensions behave as a one-pixel frame: nothing comes out.
		set_frame(0, 0);
		queue_pixels(3, PAT_WHITE);
		// Over-wide row clamps to the maximum; a single-row frame emits nothing.
		set_frame(1023, 1);
		queue_pixels(6, PAT_RANDOM);
		// Single-column frame.
		set_frame(1, 8);
		queue_pixels(8, PAT_RANDOM);
		// Smallest frame that emits: one border pixel with tlast, then a wrap
		// into the next frame.
		set_frame(4, 4);
		queue_pixels(20, PAT_CHECKER);
		// Row only as wide as the window radius, so nothing is emitted.
		set_frame(3, 9);
		queue_pixels(12, PAT_RANDOM);
		// One full window per frame: saturated mean, then all-zero mean.
		set_frame(7, 7);
		queue_pixels(49, PAT_WHITE);
		queue_pixels(49, PAT_BLACK);
		// A write to an unmapped index must not restart the frame.
		set_frame(8, 7);
		queue_pixels(30, PAT_RANDOM);
		write_reg(REG_UNMAPPED, '1);
		queue_pixels(26, PAT_RANDOM);
		// Tallest legal frame, written directly.
		set_frame(5, 512);
		queue_pixels(40, PAT_RANDOM);

		// Widest row, exact value, with an over-tall height that clamps.
		// One full row and a little more touch every line store column and
		// cross the first row wrap without emitting anything.
		send_burst = 1'b1;
		set_frame(LINE_LEN, 1023);
		queue_pixels(LINE_LEN + 2 * WIN_SPAN, PAT_RANDOM);

		// Random frames, mostly small so that full windows, borders, frame
		// ends and wraps all come up often.
		first_random = pixels_queued;
		while (pixels_queued - first_random < RANDOM_PIXELS) begin
			w = $urandom_range(4, 16);
			h = $urandom_range(4, 12);
			case ($urandom_range(0, 9))
				0:       w = $urandom_range(1, 3);
				1:       h = $urandom_range(1, 3);
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0:       pat = PAT_WHITE;
				1:       pat = PAT_BLACK;
				default: pat = PAT_RANDOM;
			endcase
			npix = $urandom_range(w * h / 2 + 1, 2 * w * h + w);

			wait_drained();
			send_burst = ($urandom_range(0, 3) == 0);
			recv_burst = ($urandom_range(0, 3) == 0);
			set_frame(w, h);

			// Now and then stop feeding halfway until the block has caught up.
			if ($urandom_range(0, 3) == 0) begin
				half = npix / 2;
				queue_pixels(half, pat);
				wait_drained();
				queue_pixels(npix - half, pat);
			end else begin
				queue_pixels(npix, pat);
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: a long stretch with no beat on any channel means the block hung.
	int quiet_cycles = 0;

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule

### files.f
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_line_store.sv
rtl/bmf_window_sum.sv
rtl/bmf_out_fifo.sv
rtl/box_mean_filter_7x7.sv
bench/tb_top.sv
